// ----- hdl/windowed_moving_average_assert.svh -----
// Assertion macros for the checker file of the moving average block
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define WMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define WMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/wma_pkg.sv -----
// Shared constants and types of the windowed moving average block
package wma_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;

  // Window size limits
  localparam int DEF_MAX_WINDOW = 16;
  localparam int WIN_DEFAULT    = 8;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_SIGN,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ----- hdl/wma_sample_if.sv -----
// Input channel carrying one raw sample per word
interface wma_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wma_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- hdl/wma_average_if.sv -----
// Output channel carrying one average per word
interface wma_average_if;
  logic                                valid;
  logic                                ready;
  logic signed [wma_pkg::SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

// ----- hdl/windowed_moving_average.sv -----
// Windowed moving average: circular sample store, serial sum and serial divider
//
//   channel    dir   handshake        payload
//   samples    in    valid / ready    sample   (signed 16)
//   averages   out   valid / ready    average  (signed 16)
//   cfg        in    cfg_we           cfg_wdata (window size, 5 bits)
//
// From accept to result, one sample takes one store write, one read per
// buffered entry through the registered read port, and one quotient bit per
// cycle in the restoring divider. samples.ready is high only in idle.
// The result sits in an output register; a stalled output blocks only the
// hand-off of the next result. rst is synchronous; no clearing pass is needed.
module windowed_moving_average #(
  parameter int MAX_WINDOW = wma_pkg::DEF_MAX_WINDOW
) (
  input  logic                         clk,
  input  logic                         rst,
  wma_sample_if.sink                   samples,
  wma_average_if.source                averages,
  input  logic                         cfg_we,
  input  logic [wma_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int AW        = $clog2(MAX_WINDOW);
  localparam int CW        = $clog2(MAX_WINDOW + 1);
  localparam int SW        = AW + wma_pkg::SAMPLE_W + 1;
  localparam int MAGW      = AW + wma_pkg::SAMPLE_W;
  localparam int DCW       = $clog2(MAGW);
  localparam int WIN_RESET = (wma_pkg::WIN_DEFAULT <= MAX_WINDOW) ?
                             wma_pkg::WIN_DEFAULT : MAX_WINDOW;

  wma_pkg::state_t state, state_next;

  logic [CW-1:0]                      window;
  logic [AW-1:0]                      wptr;
  logic [CW-1:0]                      count;
  logic [AW-1:0]                      idx;
  logic                               rd_pend;
  logic signed [wma_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [wma_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [SW-1:0]               sum;
  logic signed [SW-1:0]               sum_abs;
  logic                               neg;
  logic [MAGW-1:0]                    mag;
  logic [MAGW-1:0]                    mag_neg;
  logic [CW-1:0]                      rem;
  logic [DCW-1:0]                     dcnt;
  logic [CW:0]                        trial;
  logic [CW:0]                        diff;
  logic                               qbit;
  logic                               last_rd;
  logic                               cfg_ok;
  logic                               out_load;
  logic                               out_valid;
  logic signed [wma_pkg::SAMPLE_W-1:0] out_data;

  logic signed [wma_pkg::SAMPLE_W-1:0] store [MAX_WINDOW];

  assign samples.ready    = (state == wma_pkg::S_IDLE);
  assign averages.valid   = out_valid;
  assign averages.average = out_data;

  // Helpers for the sequencer and datapath
  assign last_rd  = ((CW'(idx) + CW'(1)) == count);
  assign cfg_ok   = cfg_we && (cfg_wdata != '0) && (32'(cfg_wdata) <= MAX_WINDOW);
  assign out_load = (state == wma_pkg::S_DONE) && (!out_valid || averages.ready);
  assign sum_abs  = sum[SW-1] ? -sum : sum;
  assign mag_neg  = -mag;

  // Restoring divider step: one quotient bit per cycle
  assign trial = {rem, mag[MAGW-1]};
  assign diff  = trial - {1'b0, count};
  assign qbit  = (trial >= {1'b0, count});

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wma_pkg::S_IDLE: begin
        if (samples.valid) state_next = wma_pkg::S_WRITE;
      end
      wma_pkg::S_WRITE: state_next = wma_pkg::S_READ;
      wma_pkg::S_READ: begin
        if (last_rd) state_next = wma_pkg::S_DRAIN;
      end
      wma_pkg::S_DRAIN: state_next = wma_pkg::S_SIGN;
      wma_pkg::S_SIGN:  state_next = wma_pkg::S_DIV;
      wma_pkg::S_DIV: begin
        if (dcnt == '0) state_next = wma_pkg::S_DONE;
      end
      wma_pkg::S_DONE: begin
        if (out_load) state_next = wma_pkg::S_IDLE;
      end
      default: state_next = wma_pkg::S_IDLE;
    endcase
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == wma_pkg::S_WRITE) begin
      store[wptr] <= sample_q;
    end
    rd_data <= store[idx];
  end

  // Control registers: window, pointer, count, read pending, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= CW'(WIN_RESET);
      wptr      <= '0;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == wma_pkg::S_READ);
      // an in-range window write restarts the buffer
      if (cfg_ok) begin
        window <= CW'(cfg_wdata);
        wptr   <= '0;
        count  <= '0;
      end else if (state == wma_pkg::S_WRITE) begin
        wptr  <= ((CW'(wptr) + CW'(1)) == window) ? '0 : wptr + 1'b1;
        count <= (count < window) ? count + CW'(1) : count;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: latch, accumulate, divide, output
  always_ff @(posedge clk) begin
    case (state)
      wma_pkg::S_IDLE: begin
        sample_q <= samples.sample;
        idx      <= '0;
      end
      wma_pkg::S_READ: begin
        idx <= idx + 1'b1;
      end
      wma_pkg::S_SIGN: begin
        neg  <= sum[SW-1];
        mag  <= sum_abs[MAGW-1:0];
        rem  <= '0;
        dcnt <= DCW'(MAGW - 1);
      end
      wma_pkg::S_DIV: begin
        rem  <= qbit ? diff[CW-1:0] : trial[CW-1:0];
        mag  <= {mag[MAGW-2:0], qbit};
        dcnt <= dcnt - 1'b1;
      end
      wma_pkg::S_DONE: begin
        if (out_load) begin
          out_data <= neg ? mag_neg[wma_pkg::SAMPLE_W-1:0] : mag[wma_pkg::SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
    // running sum over read words
    if (state == wma_pkg::S_IDLE) begin
      sum <= '0;
    end else if (rd_pend) begin
      sum <= sum + SW'(rd_data);
    end
  end

endmodule

// ----- hdl/wma_checker.sv -----
// Port-level checker for the moving average block, with its bind
`include "windowed_moving_average_assert.svh"

module wma_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [wma_pkg::SAMPLE_W-1:0] out_average
);

  // A stalled result word stays offered
  `WMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")

  // A stalled result word keeps its value
  `WMA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_average), "output word changed")

  // One word at a time: busy right after accepting a sample
  `WMA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "accepted two samples back to back")

  // The average goes through the read and divide steps: no new result right after a sample
  `WMA_ASSERT_NEXT(a_no_early, in_valid && in_ready, !$rose(out_valid), "result came too early")

endmodule

bind windowed_moving_average wma_checker u_wma_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (averages.valid),
  .out_ready   (averages.ready),
  .out_average (averages.average)
);

// ----- tb/windowed_moving_average_tb.sv -----
// Self-checking testbench for the windowed moving average block
module windowed_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [wma_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [wma_pkg::CFG_W-1:0] window_t;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        value;
    bit        has_typed;
    int        typed_avg;
  } stim_row_t;

  localparam int NUM_ROWS = 26;
  localparam int NUM_PHASES = 12;
  localparam int MAX_BURST = 18;

  logic clk;
  logic rst;
  logic cfg_we;
  window_t cfg_wdata;

  wma_sample_if samples_ch ();
  wma_average_if averages_ch ();

  windowed_moving_average uut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_ch),
    .averages (averages_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the filter state
  sample_t window_store [wma_pkg::DEF_MAX_WINDOW];
  logic [3:0] wr_ptr;
  logic [4:0] fill_count;
  window_t window_len;

  sample_t avg_expected [$];
  sample_t last_sample;
  int mismatch_count = 0;
  int samples_sent = 0;
  int averages_checked = 0;
  int window_writes = 0;
  int idle_pct = 0;

  // Directed words: extremes, truncation, ignored writes, rewrite of same size
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, 32767, 1'b1, 32767},
    '{ROW_SAMPLE, -32768, 1'b1, 0},      // -1/2 truncates toward zero
    '{ROW_SAMPLE, -3, 1'b1, -1},         // -4/3 truncates toward zero
    '{ROW_SAMPLE, 0, 1'b0, 0},
    '{ROW_WINDOW, 1, 1'b0, 0},
    '{ROW_SAMPLE, -32768, 1'b1, -32768},
    '{ROW_SAMPLE, 32767, 1'b1, 32767},
    '{ROW_WINDOW, 0, 1'b0, 0},           // zero size ignored
    '{ROW_SAMPLE, 100, 1'b1, 100},
    '{ROW_WINDOW, 17, 1'b0, 0},          // just past the limit, ignored
    '{ROW_SAMPLE, -1, 1'b1, -1},
    '{ROW_WINDOW, 31, 1'b0, 0},          // all ones, ignored
    '{ROW_SAMPLE, 1, 1'b1, 1},
    '{ROW_WINDOW, 16, 1'b0, 0},
    '{ROW_SAMPLE, -32768, 1'b1, -32768},
    '{ROW_SAMPLE, -32768, 1'b1, -32768},
    '{ROW_SAMPLE, 32767, 1'b0, 0},
    '{ROW_SAMPLE, 7, 1'b0, 0},
    '{ROW_SAMPLE, 21845, 1'b0, 0},
    '{ROW_SAMPLE, -21846, 1'b0, 0},
    '{ROW_WINDOW, 16, 1'b0, 0},          // same size again still clears
    '{ROW_SAMPLE, 9, 1'b1, 9},
    '{ROW_WINDOW, 2, 1'b0, 0},
    '{ROW_SAMPLE, 3, 1'b1, 3},
    '{ROW_SAMPLE, -4, 1'b0, 0},
    '{ROW_SAMPLE, 5, 1'b0, 0}            // pointer wraps at two
  };

  // Window sizes per random phase; -1 picks any 5-bit value
  int phase_windows [NUM_PHASES] = '{16, 1, 2, -1, 15, 0, -1, 31, 16, -1, 3, 8};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("windowed_moving_average_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void clear_window_state();
    for (int i = 0; i < wma_pkg::DEF_MAX_WINDOW; i++) window_store[i] = '0;
    wr_ptr = '0;
    fill_count = '0;
  endfunction

  // Register write as the block sees it: out-of-range sizes leave all untouched
  function automatic void apply_window_write(input window_t v);
    if (v >= 1 && v <= wma_pkg::DEF_MAX_WINDOW) begin
      window_len = v;
      clear_window_state();
    end
  endfunction

  // Store the word, advance pointer and fill, average the filled entries
  function automatic sample_t predict_average(input sample_t s);
    int sum;
    int avg;
    sum = 0;
    window_store[wr_ptr] = s;
    wr_ptr = 4'((int'(wr_ptr) + 1) % int'(window_len));
    if (fill_count < window_len) fill_count++;
    for (int i = 0; i < int'(fill_count); i++) sum += int'(window_store[i]);
    avg = sum / int'(fill_count);
    return sample_t'(avg);
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2: return ($urandom_range(0, 1) != 0) ? sample_t'(0) : sample_t'(-1);
      3: return sample_t'(int'($urandom_range(0, 15)) - 8);
      4: return last_sample;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Send one word, optionally after a gap; predict once it is taken
  task automatic send_sample(input sample_t s, input bit has_typed, input sample_t typed_avg);
    sample_t predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      // half the gaps are placed where the block is waiting for input
      if ($urandom_range(0, 1) != 0) begin
        do @(posedge clk); while (!samples_ch.ready);
      end
      repeat ($urandom_range(1, MAX_BURST)) @(negedge clk);
    end
    @(negedge clk);
    samples_ch.valid <= 1'b1;
    samples_ch.sample <= s;
    do @(posedge clk); while (!samples_ch.ready);
    predicted = predict_average(s);
    avg_expected.push_back(has_typed ? typed_avg : predicted);
    last_sample = s;
    samples_sent++;
    @(negedge clk);
    samples_ch.valid <= 1'b0;
  endtask

  // Size writes only once every average has drained
  task automatic write_window(input window_t v);
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_window_write(v);
    window_writes++;
  endtask

  // Output side: random stall bursts on ready
  initial begin
    int stall_left;
    stall_left = 0;
    averages_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        averages_ch.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
          stall_left = $urandom_range(1, MAX_BURST);
        if (stall_left > 0) begin
          averages_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          averages_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Compare each average word with the oldest prediction
  always @(posedge clk) begin : check_average
    sample_t want;
    if (!rst && averages_ch.valid && averages_ch.ready) begin
      if (avg_expected.size() == 0) begin
        report_mismatch($sformatf("average %0d with no sample pending", averages_ch.average));
      end else begin
        want = avg_expected.pop_front();
        averages_checked++;
        if (averages_ch.average !== want)
          report_mismatch($sformatf("average got %0d want %0d",
                                    averages_ch.average, want));
      end
    end
  end

  // Main sequence
  initial begin
    int count;
    int win;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    samples_ch.valid = 1'b0;
    samples_ch.sample = '0;
    last_sample = '0;
    window_len = window_t'(wma_pkg::WIN_DEFAULT);
    clear_window_state();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WINDOW)
        write_window(window_t'(directed_rows[r].value));
      else
        send_sample(sample_t'(directed_rows[r].value), directed_rows[r].has_typed,
                    sample_t'(directed_rows[r].typed_avg));
    end

    // Random phases, each behind a size write; the last one runs without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      win = (phase_windows[p] < 0) ? int'($urandom_range(0, 31)) : phase_windows[p];
      write_window(window_t'(win));
      if (p == NUM_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      count = $urandom_range(60, 95);
      for (int k = 0; k < count; k++) send_sample(draw_sample(), 1'b0, '0);
    end

    while (avg_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d samples, checked %0d averages, made %0d window writes",
             samples_sent, averages_checked, window_writes);
    $display("Window sizes from 1 to 16 plus ignored out-of-range writes; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0)
      $display("windowed_moving_average_tb: clean");
    else
      $display("windowed_moving_average_tb: errors");
    $finish;
  end

endmodule

// ----- windowed_moving_average.f -----
+incdir+hdl
hdl/wma_pkg.sv
hdl/wma_sample_if.sv
hdl/wma_average_if.sv
hdl/windowed_moving_average.sv
hdl/wma_checker.sv
tb/windowed_moving_average_tb.sv
